// ----- sv/fbsl_pkg.sv -----
package fbsl_pkg;

	// field and datapath widths
	localparam int DATA_W = 32;
	localparam int OPER_W = 34;
	localparam int QUO_W  = 31;
	localparam int CNT_W  = $clog2(QUO_W);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [OPER_W-1:0] oper_t;
	typedef logic [OPER_W-1:0]        mag_t;
	typedef logic [QUO_W-1:0]         quo_t;

	// one in Q1.30 and the extreme reset values
	localparam quo_t  Q30_ONE  = quo_t'(1) << (QUO_W - 1);
	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// top level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELEM_DIV,
		ST_FIN_LOW,
		ST_LOW_DIV,
		ST_FIN_HIGH,
		ST_HIGH_DIV,
		ST_EMIT
	} top_state_t;

	// serial divider sequencer
	typedef enum logic [1:0] {
		DV_IDLE,
		DV_SIGN,
		DV_CHECK,
		DV_ITER
	} div_state_t;

	typedef struct packed {
		logic  start;
		oper_t num;
		oper_t den;
	} div_req_t;

	typedef struct packed {
		logic done;
		quo_t cand;
		logic err;
	} div_res_t;

	typedef struct packed {
		logic beat;
		logic clr;
		logic bump_low;
		logic bump_high;
		logic clear_ext;
	} stats_ctrl_t;

endpackage

// ----- sv/fraction_bound_step_limiter_core.sv -----
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  old_fraction, new_fraction, last_element,
//                                          clear_statistics
// out      output     out_valid / out_stall reduction_factor, low_corrections,
//                                          high_corrections, smallest_new, largest_new,
//                                          bound_error
// cfg      input      cfg_valid / cfg_ready robust_mode
//
// an element with no division leaves the sequencer idle for the next element; a division
// stalls the input for a sign check, a range check, 31 quotient bits and the result, and
// ends early after the sign or range check; a last element adds two end checks (low, high),
// a low (non-robust) and a high division when needed, and the load of the output register
// arst_n clears the sequencer, the running factor, the counters and the extremes
// a held result stalls the input once the next result is waiting to be emitted
module fraction_bound_step_limiter_core #(
	parameter int FRACTION_BITS = 28,
	parameter int COUNT_WIDTH   = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    robust_mode,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  fbsl_pkg::data_t         old_fraction,
	input  fbsl_pkg::data_t         new_fraction,
	input  logic                    last_element,
	input  logic                    clear_statistics,

	output logic                    out_valid,
	input  logic                    out_stall,
	output fbsl_pkg::quo_t          reduction_factor,
	output logic [COUNT_WIDTH-1:0]  low_corrections,
	output logic [COUNT_WIDTH-1:0]  high_corrections,
	output fbsl_pkg::data_t         smallest_new,
	output fbsl_pkg::data_t         largest_new,
	output logic                    bound_error
);

	localparam int EXT_W = fbsl_pkg::OPER_W - fbsl_pkg::DATA_W;
	localparam fbsl_pkg::oper_t ONE_Q = fbsl_pkg::oper_t'(1) << FRACTION_BITS;

	fbsl_pkg::top_state_t state_q, state_d;

	logic            robust_q;
	logic            last_q;
	fbsl_pkg::quo_t  rf_q;
	logic            err_q;

	logic                   out_valid_q;
	fbsl_pkg::quo_t         rf_out_q;
	logic [COUNT_WIDTH-1:0] low_out_q, high_out_q;
	fbsl_pkg::data_t        min_out_q, max_out_q;
	logic                   err_out_q;

	fbsl_pkg::div_req_t    div_req;
	fbsl_pkg::div_res_t    div_res;
	fbsl_pkg::stats_ctrl_t st_ctrl;

	fbsl_pkg::data_t        min_new, old_at_min, max_new, old_at_max;
	logic [COUNT_WIDTH-1:0] low_cnt, high_cnt;

	logic            accept, elem_neg, emit;
	fbsl_pkg::oper_t old_ext, new_ext, min_ext, oam_ext, max_ext, oax_ext;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robust_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			robust_q <= robust_mode;
		end
	end

	// sign-extended operands
	always_comb begin
		old_ext = {{EXT_W{old_fraction[fbsl_pkg::DATA_W-1]}}, old_fraction};
		new_ext = {{EXT_W{new_fraction[fbsl_pkg::DATA_W-1]}}, new_fraction};
		min_ext = {{EXT_W{min_new[fbsl_pkg::DATA_W-1]}}, min_new};
		oam_ext = {{EXT_W{old_at_min[fbsl_pkg::DATA_W-1]}}, old_at_min};
		max_ext = {{EXT_W{max_new[fbsl_pkg::DATA_W-1]}}, max_new};
		oax_ext = {{EXT_W{old_at_max[fbsl_pkg::DATA_W-1]}}, old_at_max};
	end

	// sequencer: next state, divider requests and stats control
	always_comb begin
		state_d           = state_q;
		in_stall          = (state_q != fbsl_pkg::ST_IDLE);
		accept            = in_valid && !in_stall;
		elem_neg          = robust_q && new_fraction[fbsl_pkg::DATA_W-1];
		emit              = 1'b0;
		div_req.start     = 1'b0;
		div_req.num       = old_ext;
		div_req.den       = old_ext - new_ext;
		st_ctrl.beat      = 1'b0;
		st_ctrl.clr       = clear_statistics;
		st_ctrl.bump_low  = 1'b0;
		st_ctrl.bump_high = 1'b0;
		st_ctrl.clear_ext = 1'b0;
		case (state_q)
			fbsl_pkg::ST_IDLE: begin
				if (accept) begin
					st_ctrl.beat     = 1'b1;
					st_ctrl.bump_low = elem_neg;
					div_req.start    = elem_neg;
					if (elem_neg) begin
						state_d = fbsl_pkg::ST_ELEM_DIV;
					end else if (last_element) begin
						state_d = fbsl_pkg::ST_FIN_LOW;
					end
				end
			end
			fbsl_pkg::ST_ELEM_DIV: begin
				if (div_res.done) begin
					state_d = last_q ? fbsl_pkg::ST_FIN_LOW : fbsl_pkg::ST_IDLE;
				end
			end
			fbsl_pkg::ST_FIN_LOW: begin
				div_req.num = oam_ext;
				div_req.den = oam_ext - min_ext;
				if (!robust_q && min_new[fbsl_pkg::DATA_W-1]) begin
					st_ctrl.bump_low = 1'b1;
					div_req.start    = 1'b1;
					state_d          = fbsl_pkg::ST_LOW_DIV;
				end else begin
					state_d = fbsl_pkg::ST_FIN_HIGH;
				end
			end
			fbsl_pkg::ST_LOW_DIV: begin
				if (div_res.done) state_d = fbsl_pkg::ST_FIN_HIGH;
			end
			fbsl_pkg::ST_FIN_HIGH: begin
				div_req.num = ONE_Q - oax_ext;
				div_req.den = max_ext - oax_ext;
				if (max_ext > ONE_Q) begin
					st_ctrl.bump_high = 1'b1;
					div_req.start     = 1'b1;
					state_d           = fbsl_pkg::ST_HIGH_DIV;
				end else begin
					state_d = fbsl_pkg::ST_EMIT;
				end
			end
			fbsl_pkg::ST_HIGH_DIV: begin
				if (div_res.done) state_d = fbsl_pkg::ST_EMIT;
			end
			fbsl_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit              = 1'b1;
					st_ctrl.clear_ext = 1'b1;
					state_d           = fbsl_pkg::ST_IDLE;
				end
			end
			default: state_d = fbsl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) last_q <= last_element;
	end

	// running factor keeps the smallest candidate of the vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q  <= fbsl_pkg::Q30_ONE;
			err_q <= 1'b0;
		end else if (emit) begin
			rf_q  <= fbsl_pkg::Q30_ONE;
			err_q <= 1'b0;
		end else if (div_res.done) begin
			if (div_res.cand < rf_q) rf_q <= div_res.cand;
			err_q <= err_q || div_res.err;
		end
	end

	// output register, one result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rf_out_q   <= rf_q;
			low_out_q  <= low_cnt;
			high_out_q <= high_cnt;
			min_out_q  <= min_new;
			max_out_q  <= max_new;
			err_out_q  <= err_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign reduction_factor = rf_out_q;
	assign low_corrections  = low_out_q;
	assign high_corrections = high_out_q;
	assign smallest_new     = min_out_q;
	assign largest_new      = max_out_q;
	assign bound_error      = err_out_q;

	fbsl_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	fbsl_stats #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (st_ctrl),
		.old_val    (old_fraction),
		.new_val    (new_fraction),
		.min_new    (min_new),
		.old_at_min (old_at_min),
		.max_new    (max_new),
		.old_at_max (old_at_max),
		.low_cnt    (low_cnt),
		.high_cnt   (high_cnt)
	);

`ifndef SYNTHESIS
	// factor never exceeds one
	a_factor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rf_q <= fbsl_pkg::Q30_ONE)
		else $error("running factor above one");

	// divider answers only while the sequencer waits for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == fbsl_pkg::ST_ELEM_DIV ||
		                  state_q == fbsl_pkg::ST_LOW_DIV ||
		                  state_q == fbsl_pkg::ST_HIGH_DIV))
		else $error("divider result outside a wait state");

	// a new result never overwrites one still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

	// low counter only grows unless cleared
	a_low_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && clear_statistics) |=> low_cnt >= $past(low_cnt))
		else $error("low counter decreased");
`endif

endmodule

// ----- sv/fbsl_divider.sv -----
module fbsl_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  fbsl_pkg::div_req_t  req,
	output fbsl_pkg::div_res_t  res
);

	fbsl_pkg::div_state_t state_q, state_d;

	fbsl_pkg::oper_t num_q, den_q;
	fbsl_pkg::mag_t  un_q, ud_q;
	logic [fbsl_pkg::OPER_W:0]   rem_q;
	fbsl_pkg::quo_t  quo_q;
	logic [fbsl_pkg::CNT_W-1:0]  cnt_q;
	logic            done_q;
	logic            err_q;
	fbsl_pkg::quo_t  cand_q;

	logic            num_neg, den_neg, num_zero, den_zero, sign_bad, early_out;
	fbsl_pkg::mag_t  un_abs, ud_abs;
	logic            over;
	logic            rem_ge;
	logic [fbsl_pkg::OPER_W:0]   rem_sub;
	logic            last_step;

	// operand signs and magnitudes
	always_comb begin
		num_neg   = num_q[fbsl_pkg::OPER_W-1];
		den_neg   = den_q[fbsl_pkg::OPER_W-1];
		num_zero  = (num_q == '0);
		den_zero  = (den_q == '0);
		sign_bad  = !num_zero && (num_neg != den_neg);
		early_out = den_zero || sign_bad;
		un_abs    = fbsl_pkg::mag_t'(num_neg ? -num_q : num_q);
		ud_abs    = fbsl_pkg::mag_t'(den_neg ? -den_q : den_q);
		over      = (un_q > ud_q);
	end

	// one quotient bit per cycle: compare, subtract, shift
	always_comb begin
		rem_ge    = (rem_q >= {1'b0, ud_q});
		rem_sub   = rem_ge ? (rem_q - {1'b0, ud_q}) : rem_q;
		last_step = (cnt_q == fbsl_pkg::CNT_W'(fbsl_pkg::QUO_W - 1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fbsl_pkg::DV_IDLE: begin
				if (req.start) state_d = fbsl_pkg::DV_SIGN;
			end
			fbsl_pkg::DV_SIGN: begin
				state_d = early_out ? fbsl_pkg::DV_IDLE : fbsl_pkg::DV_CHECK;
			end
			fbsl_pkg::DV_CHECK: begin
				state_d = over ? fbsl_pkg::DV_IDLE : fbsl_pkg::DV_ITER;
			end
			fbsl_pkg::DV_ITER: begin
				if (last_step) state_d = fbsl_pkg::DV_IDLE;
			end
			default: state_d = fbsl_pkg::DV_IDLE;
		endcase
	end

	// state and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbsl_pkg::DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == fbsl_pkg::DV_SIGN) && early_out) ||
			           ((state_q == fbsl_pkg::DV_CHECK) && over) ||
			           ((state_q == fbsl_pkg::DV_ITER) && last_step);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			fbsl_pkg::DV_IDLE: begin
				if (req.start) begin
					num_q <= req.num;
					den_q <= req.den;
				end
			end
			fbsl_pkg::DV_SIGN: begin
				if (early_out) begin
					err_q  <= 1'b1;
					cand_q <= '0;
				end else begin
					un_q <= un_abs;
					ud_q <= ud_abs;
				end
			end
			fbsl_pkg::DV_CHECK: begin
				if (over) begin
					err_q  <= 1'b1;
					cand_q <= fbsl_pkg::Q30_ONE;
				end else begin
					rem_q <= {1'b0, un_q};
					cnt_q <= '0;
				end
			end
			fbsl_pkg::DV_ITER: begin
				rem_q <= {rem_sub[fbsl_pkg::OPER_W-1:0], 1'b0};
				quo_q <= {quo_q[fbsl_pkg::QUO_W-2:0], rem_ge};
				cnt_q <= cnt_q + fbsl_pkg::CNT_W'(1);
				if (last_step) begin
					err_q  <= 1'b0;
					cand_q <= {quo_q[fbsl_pkg::QUO_W-2:0], rem_ge};
				end
			end
			default: begin
			end
		endcase
	end

	assign res.done = done_q;
	assign res.cand = cand_q;
	assign res.err  = err_q;

endmodule

// ----- sv/fbsl_stats.sv -----
module fbsl_stats #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fbsl_pkg::stats_ctrl_t   ctrl,
	input  fbsl_pkg::data_t         old_val,
	input  fbsl_pkg::data_t         new_val,
	output fbsl_pkg::data_t         min_new,
	output fbsl_pkg::data_t         old_at_min,
	output fbsl_pkg::data_t         max_new,
	output fbsl_pkg::data_t         old_at_max,
	output logic [COUNT_WIDTH-1:0]  low_cnt,
	output logic [COUNT_WIDTH-1:0]  high_cnt
);

	fbsl_pkg::data_t min_q, oam_q, max_q, oax_q;
	logic [COUNT_WIDTH-1:0] low_q, high_q;

	logic                   clr;
	logic [COUNT_WIDTH-1:0] low_base, high_base, low_next, high_next;
	fbsl_pkg::data_t        min_base, oam_base, max_base, oax_base;
	logic                   take_min, take_max;

	// clear applies before the beat's own update
	always_comb begin
		clr       = ctrl.beat && ctrl.clr;
		low_base  = clr ? '0 : low_q;
		high_base = clr ? '0 : high_q;
		low_next  = (ctrl.bump_low && (low_base != '1)) ?
		            low_base + COUNT_WIDTH'(1) : low_base;
		high_next = (ctrl.bump_high && (high_base != '1)) ?
		            high_base + COUNT_WIDTH'(1) : high_base;
		min_base  = clr ? fbsl_pkg::DATA_MAX : min_q;
		oam_base  = clr ? '0 : oam_q;
		max_base  = clr ? fbsl_pkg::DATA_MIN : max_q;
		oax_base  = clr ? '0 : oax_q;
		take_min  = (new_val < min_base);
		take_max  = (new_val > max_base);
	end

	// counters and extremes, ties keep the earlier element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			min_q  <= fbsl_pkg::DATA_MAX;
			oam_q  <= '0;
			max_q  <= fbsl_pkg::DATA_MIN;
			oax_q  <= '0;
		end else begin
			low_q  <= low_next;
			high_q <= high_next;
			if (ctrl.clear_ext) begin
				min_q <= fbsl_pkg::DATA_MAX;
				oam_q <= '0;
				max_q <= fbsl_pkg::DATA_MIN;
				oax_q <= '0;
			end else if (ctrl.beat) begin
				min_q <= take_min ? new_val : min_base;
				oam_q <= take_min ? old_val : oam_base;
				max_q <= take_max ? new_val : max_base;
				oax_q <= take_max ? old_val : oax_base;
			end
		end
	end

	assign min_new    = min_q;
	assign old_at_min = oam_q;
	assign max_new    = max_q;
	assign old_at_max = oax_q;
	assign low_cnt    = low_q;
	assign high_cnt   = high_q;

endmodule

// ----- dv/fraction_bound_step_limiter_core_test.sv -----
module fraction_bound_step_limiter_core_test;

	localparam int    TALLY_W     = 24;
	localparam int    SETTLE      = 128;
	localparam int    STALL_LIMIT = 4000;
	localparam int    HOLD_CYCLES = 600;
	localparam fbsl_pkg::data_t UNIT_Q28 = fbsl_pkg::data_t'(32'sd1 <<< 28);

	typedef struct {
		fbsl_pkg::quo_t     factor;
		logic [TALLY_W-1:0] lows;
		logic [TALLY_W-1:0] highs;
		fbsl_pkg::data_t    smin;
		fbsl_pkg::data_t    smax;
		logic               err;
	} limit_result_t;

	// clock and dut ports
	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               cfg_valid        = 1'b0;
	logic               cfg_ready;
	logic               robust_mode      = 1'b1;
	logic               in_valid         = 1'b0;
	logic               in_stall;
	fbsl_pkg::data_t    old_fraction     = '0;
	fbsl_pkg::data_t    new_fraction     = '0;
	logic               last_element     = 1'b0;
	logic               clear_statistics = 1'b0;
	logic               out_valid;
	logic               out_stall        = 1'b0;
	fbsl_pkg::quo_t     reduction_factor;
	logic [TALLY_W-1:0] low_corrections;
	logic [TALLY_W-1:0] high_corrections;
	fbsl_pkg::data_t    smallest_new;
	fbsl_pkg::data_t    largest_new;
	logic               bound_error;

	// predicted block state
	bit                 mode_reg = 1'b1;
	logic [63:0]        step_factor;
	logic [TALLY_W-1:0] low_tally;
	logic [TALLY_W-1:0] high_tally;
	fbsl_pkg::data_t    min_seen;
	fbsl_pkg::data_t    old_at_min_seen;
	fbsl_pkg::data_t    max_seen;
	fbsl_pkg::data_t    old_at_max_seen;
	bit                 err_flag;

	limit_result_t      pending_results[$];
	int                 fail_count    = 0;
	int                 gap_pct       = 0;
	int                 stall_pct     = 0;
	logic               hold_request  = 1'b0;
	int                 quiet_cycles  = 0;

	always #10 clk = ~clk;

	fraction_bound_step_limiter_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.robust_mode      (robust_mode),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.old_fraction     (old_fraction),
		.new_fraction     (new_fraction),
		.last_element     (last_element),
		.clear_statistics (clear_statistics),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.reduction_factor (reduction_factor),
		.low_corrections  (low_corrections),
		.high_corrections (high_corrections),
		.smallest_new     (smallest_new),
		.largest_new      (largest_new),
		.bound_error      (bound_error)
	);

	// extremes go back to their empty values
	function automatic void clear_extremes();
		min_seen        = fbsl_pkg::DATA_MAX;
		old_at_min_seen = '0;
		max_seen        = fbsl_pkg::DATA_MIN;
		old_at_max_seen = '0;
	endfunction

	// factor = min(factor, num/den) with clamping to zero..one
	function automatic void narrow_factor(longint num, longint den);
		logic [63:0] un;
		logic [63:0] ud;
		logic [63:0] cand;
		if (den == 0) begin
			err_flag = 1'b1;
			cand     = '0;
		end else if (num != 0 && ((num < 0) != (den < 0))) begin
			err_flag = 1'b1;
			cand     = '0;
		end else begin
			un = (num < 0) ? -num : num;
			ud = (den < 0) ? -den : den;
			if (un > ud) begin
				err_flag = 1'b1;
				cand     = 64'(fbsl_pkg::Q30_ONE);
			end else begin
				cand = (un << 30) / ud;
			end
		end
		if (cand < step_factor)
			step_factor = cand;
	endfunction

	// one accepted element through the predictor
	function automatic void predict_element(fbsl_pkg::data_t old_v, fbsl_pkg::data_t new_v,
		bit last, bit clr);
		limit_result_t res;
		if (clr) begin
			low_tally  = '0;
			high_tally = '0;
			clear_extremes();
		end
		if (mode_reg && new_v < 0) begin
			if (low_tally != '1)
				low_tally++;
			narrow_factor(longint'(old_v), longint'(old_v) - longint'(new_v));
		end
		if (new_v < min_seen) begin
			min_seen        = new_v;
			old_at_min_seen = old_v;
		end
		if (new_v > max_seen) begin
			max_seen        = new_v;
			old_at_max_seen = old_v;
		end
		if (!last)
			return;
		// end of vector: smallest-value check and the high correction
		if (!mode_reg && min_seen < 0) begin
			if (low_tally != '1)
				low_tally++;
			narrow_factor(longint'(old_at_min_seen),
				longint'(old_at_min_seen) - longint'(min_seen));
		end
		if (max_seen > UNIT_Q28) begin
			if (high_tally != '1)
				high_tally++;
			narrow_factor(longint'(UNIT_Q28) - longint'(old_at_max_seen),
				longint'(max_seen) - longint'(old_at_max_seen));
		end
		res.factor = fbsl_pkg::quo_t'(step_factor);
		res.lows   = low_tally;
		res.highs  = high_tally;
		res.smin   = min_seen;
		res.smax   = max_seen;
		res.err    = err_flag;
		pending_results.push_back(res);
		step_factor = 64'(fbsl_pkg::Q30_ONE);
		err_flag    = 1'b0;
		clear_extremes();
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		limit_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no prediction waiting");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("reduction_factor", want.factor, reduction_factor);
				check_field("low_corrections", want.lows, low_corrections);
				check_field("high_corrections", want.highs, high_corrections);
				check_field("smallest_new", want.smin, smallest_new);
				check_field("largest_new", want.smax, largest_new);
				check_field("bound_error", want.err, bound_error);
			end
		end
	end

	// receiver: random stall, or a long hold-off on request
	always begin
		@(posedge clk);
		if (hold_request) begin
			for (int k = 0; k < HOLD_CYCLES; k++) begin
				out_stall <= 1'b1;
				@(posedge clk);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** fraction_bound_step_limiter_core: FAILED **");
			$finish;
		end
	end

	task automatic send_element(input fbsl_pkg::data_t old_v, input fbsl_pkg::data_t new_v,
		input bit last, input bit clr);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid         <= 1'b1;
		old_fraction     <= old_v;
		new_fraction     <= new_v;
		last_element     <= last;
		clear_statistics <= clr;
		do @(posedge clk); while (in_stall);
		predict_element(old_v, new_v, last, clr);
	endtask

	// sender pauses until every result is back and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		drain();
		cfg_valid   <= 1'b1;
		robust_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_reg  = m;
	endtask

	function automatic fbsl_pkg::data_t pick_fraction(bit is_new);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return fbsl_pkg::data_t'($urandom());
		if (sel < 14) begin
			case ($urandom_range(5))
				0: return '0;
				1: return UNIT_Q28;
				2: return UNIT_Q28 + 1;
				3: return -1;
				4: return fbsl_pkg::DATA_MAX;
				default: return fbsl_pkg::DATA_MIN;
			endcase
		end
		if (sel < 30)
			return fbsl_pkg::data_t'(int'($urandom_range(0, 5 * UNIT_Q28)) - 2 * UNIT_Q28);
		if (is_new)
			return fbsl_pkg::data_t'(int'($urandom_range(0, 2 * UNIT_Q28)) - UNIT_Q28 / 2);
		return fbsl_pkg::data_t'($urandom_range(0, UNIT_Q28));
	endfunction

	// vectors of random length with random content
	task automatic run_vectors(input int item_count);
		int sent;
		int vec_len;
		sent = 0;
		while (sent < item_count) begin
			vec_len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
			for (int i = 0; i < vec_len; i++) begin
				send_element(pick_fraction(1'b0), pick_fraction(1'b1), i == vec_len - 1,
					$urandom_range(19) == 0);
				sent++;
			end
		end
	endtask

	// full-scale values in both fields
	task automatic test_field_extremes();
		send_element(fbsl_pkg::DATA_MIN, fbsl_pkg::DATA_MIN, 1'b1, 1'b0);
		send_element(fbsl_pkg::DATA_MAX, fbsl_pkg::DATA_MAX, 1'b1, 1'b0);
		send_element(fbsl_pkg::DATA_MAX, fbsl_pkg::DATA_MIN, 1'b1, 1'b1);
		send_element(fbsl_pkg::DATA_MIN, fbsl_pkg::DATA_MAX, 1'b1, 1'b0);
	endtask

	// zero divisor, negative candidate, candidate above one, low and high side
	task automatic test_candidate_clamps();
		send_element(-UNIT_Q28 / 2, -UNIT_Q28 / 2, 1'b1, 1'b0);
		send_element(-UNIT_Q28 / 2, -UNIT_Q28, 1'b1, 1'b0);
		send_element(-UNIT_Q28, -UNIT_Q28 / 2, 1'b1, 1'b0);
		send_element(2 * UNIT_Q28, 3 * UNIT_Q28, 1'b1, 1'b0);
		send_element(3 * UNIT_Q28, 2 * UNIT_Q28, 1'b1, 1'b0);
	endtask

	// thresholds at zero and one, plus a vector with both corrections
	task automatic test_corrections();
		send_element(UNIT_Q28 / 2, '0, 1'b1, 1'b1);
		send_element(UNIT_Q28 / 2, UNIT_Q28, 1'b1, 1'b0);
		send_element(UNIT_Q28 / 2, UNIT_Q28 + 1, 1'b1, 1'b0);
		send_element(UNIT_Q28 / 2, -1, 1'b1, 1'b0);
		send_element(UNIT_Q28 / 4, -UNIT_Q28 / 4, 1'b0, 1'b0);
		send_element(UNIT_Q28 / 2, UNIT_Q28 + UNIT_Q28 / 2, 1'b1, 1'b0);
	endtask

	// equal minimums keep the earlier old value; clear in the middle of a vector
	task automatic test_ties_and_clear();
		write_mode(1'b0);
		send_element(UNIT_Q28 / 2, -UNIT_Q28 / 8, 1'b0, 1'b0);
		send_element(UNIT_Q28 / 4, -UNIT_Q28 / 8, 1'b1, 1'b0);
		send_element(UNIT_Q28 / 2, -UNIT_Q28 / 8, 1'b0, 1'b0);
		send_element(UNIT_Q28 / 2, UNIT_Q28 / 2, 1'b1, 1'b1);
	endtask

	// mode taken per element, smallest-value check with the mode at the last one
	task automatic test_mode_switch();
		send_element(UNIT_Q28 / 2, -UNIT_Q28 / 2, 1'b0, 1'b0);
		write_mode(1'b1);
		send_element(UNIT_Q28 / 2, -UNIT_Q28 / 4, 1'b1, 1'b0);
		send_element(UNIT_Q28 / 2, -UNIT_Q28 / 4, 1'b0, 1'b0);
		write_mode(1'b0);
		send_element(UNIT_Q28 / 4, -UNIT_Q28 / 2, 1'b0, 1'b0);
		send_element(UNIT_Q28 / 4, UNIT_Q28 / 2, 1'b1, 1'b0);
	endtask

	task automatic test_random_phase(input bit m, input int gap, input int stall, input int n);
		write_mode(m);
		gap_pct   = gap;
		stall_pct <= stall;
		run_vectors(n);
	endtask

	// long receiver hold-off while the sender keeps offering beats
	task automatic test_backpressure();
		gap_pct      = 0;
		stall_pct    <= 0;
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		for (int i = 0; i < 40; i++)
			send_element(pick_fraction(1'b0), pick_fraction(1'b1), i % 4 != 1, 1'b0);
		send_element(UNIT_Q28 / 2, -UNIT_Q28 / 2, 1'b1, 1'b0);
		drain();
	endtask

	initial begin
		step_factor = 64'(fbsl_pkg::Q30_ONE);
		low_tally   = '0;
		high_tally  = '0;
		err_flag    = 1'b0;
		clear_extremes();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_candidate_clamps();
		test_corrections();
		test_ties_and_clear();
		test_mode_switch();
		test_random_phase(1'b1, 0, 0, 400);
		test_random_phase(1'b0, 70, 0, 400);
		test_random_phase(1'b1, 0, 70, 400);
		test_random_phase(1'b0, 22, 22, 400);
		write_mode(1'b1);
		test_backpressure();

		drain();
		if (pending_results.size() != 0) begin
			$error("%0d predicted results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("** fraction_bound_step_limiter_core: PASSED **");
		else
			$display("** fraction_bound_step_limiter_core: FAILED **");
		$finish;
	end

endmodule
